>>> src/bpa_pkg.sv
`default_nettype none
package bpa_pkg;

  localparam int PAGE_W    = 10;
  localparam int ORD_W     = 4;
  localparam int LINK_W    = PAGE_W + 1;
  localparam int MAX_ORDER = 10;
  localparam int PAGE_NUM  = 1 << PAGE_W;
  localparam int CFG_W     = 11;

  // A link with its top bit set points nowhere.
  localparam logic [LINK_W-1:0] NIL_LINK = {1'b1, {PAGE_W{1'b0}}};

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_MEM   = 2'd1;
  localparam logic [1:0] ST_BAD_FREE = 2'd2;

  // One page frame entry. nothead is the inverse of the head mark, so
  // an all-zero entry is an allocated order-0 head.
  typedef struct packed {
    logic              free;
    logic              nothead;
    logic [ORD_W-1:0]  order;
    logic [LINK_W-1:0] next_link;
    logic [LINK_W-1:0] prev_link;
  } page_entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [PAGE_W-1:0] rd_addr;
    logic              wr_en;
    logic [PAGE_W-1:0] wr_addr;
    page_entry_t       wr_data;
  } mem_req_t;

endpackage
`default_nettype wire

>>> src/bpa_page_ram.sv
`default_nettype none
module bpa_page_ram
  import bpa_pkg::*;
(
  input  wire logic        clk,
  input  wire mem_req_t    req,
  output page_entry_t      rd_data
);

  page_entry_t mem [0:PAGE_NUM-1];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> src/bpa_ctrl.sv
`default_nettype none
module bpa_ctrl
  import bpa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [CFG_W-1:0]  page_limit,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire logic              req_op,
  input  wire logic [ORD_W-1:0]  req_order,
  input  wire logic [PAGE_W-1:0] req_page,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output logic [1:0]             res_status,
  output logic [PAGE_W-1:0]      res_page,
  output mem_req_t               mem_req,
  input  wire page_entry_t       mem_q
);

  localparam logic [4:0] S_CLEAR   = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_A_START = 5'd2;
  localparam logic [4:0] S_A_SCAN  = 5'd3;
  localparam logic [4:0] S_A_SPLIT = 5'd4;
  localparam logic [4:0] S_F_START = 5'd5;
  localparam logic [4:0] S_F_HEAD  = 5'd6;
  localparam logic [4:0] S_F_LOOP  = 5'd7;
  localparam logic [4:0] S_F_BUD   = 5'd8;
  localparam logic [4:0] S_F_MERGE = 5'd9;
  localparam logic [4:0] S_U_RD    = 5'd10;
  localparam logic [4:0] S_U_GOT   = 5'd11;
  localparam logic [4:0] S_U_PV_RD = 5'd12;
  localparam logic [4:0] S_U_PV_WR = 5'd13;
  localparam logic [4:0] S_U_NX_RD = 5'd14;
  localparam logic [4:0] S_U_NX_WR = 5'd15;
  localparam logic [4:0] S_P_WR    = 5'd16;
  localparam logic [4:0] S_P_H_RD  = 5'd17;
  localparam logic [4:0] S_P_H_WR  = 5'd18;
  localparam logic [4:0] S_DONE    = 5'd19;

  localparam logic [ORD_W-1:0] ORD_MAX = ORD_W'(MAX_ORDER);

  logic [4:0]        state;
  logic [4:0]        ret;
  logic [ORD_W-1:0]  lvl;
  logic [ORD_W-1:0]  want;
  logic [PAGE_W-1:0] p;
  logic [PAGE_W-1:0] bud;
  logic [PAGE_W-1:0] ul;
  logic [PAGE_W-1:0] pp;
  logic [LINK_W-1:0] nx;
  logic [LINK_W-1:0] pv;
  logic [LINK_W-1:0] hreg;
  logic [PAGE_W-1:0] clr;
  logic [LINK_W-1:0] head [0:MAX_ORDER];

  logic [LINK_W-1:0] head_sel;
  logic [PAGE_W-1:0] bud_c;
  logic [PAGE_W-1:0] split_c;
  logic              bud_ok;

  assign head_sel = (lvl <= ORD_MAX) ? head[lvl] : NIL_LINK;
  assign bud_c    = p ^ (PAGE_W'(1) << lvl);
  assign split_c  = p ^ (PAGE_W'(1) << (lvl - ORD_W'(1)));
  assign bud_ok   = (lvl < ORD_MAX) && ({1'b0, bud_c} < page_limit);

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    mem_req = '0;
    unique case (state)
      S_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = clr;
      end
      S_F_START: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = p;
      end
      S_F_LOOP: begin
        mem_req.rd_en   = bud_ok;
        mem_req.rd_addr = bud_c;
      end
      S_F_MERGE: begin
        mem_req.wr_en           = 1'b1;
        mem_req.wr_addr         = (bud > p) ? bud : p;
        mem_req.wr_data.nothead = 1'b1;
      end
      S_A_SPLIT: begin
        mem_req.wr_en         = (lvl == want);
        mem_req.wr_addr       = p;
        mem_req.wr_data.order = want;
      end
      S_U_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = ul;
      end
      S_U_PV_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = pv[PAGE_W-1:0];
      end
      S_U_PV_WR: begin
        mem_req.wr_en             = 1'b1;
        mem_req.wr_addr           = pv[PAGE_W-1:0];
        mem_req.wr_data           = mem_q;
        mem_req.wr_data.next_link = nx;
      end
      S_U_NX_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = nx[PAGE_W-1:0];
      end
      S_U_NX_WR: begin
        mem_req.wr_en             = 1'b1;
        mem_req.wr_addr           = nx[PAGE_W-1:0];
        mem_req.wr_data           = mem_q;
        mem_req.wr_data.prev_link = pv;
      end
      S_P_WR: begin
        mem_req.wr_en             = 1'b1;
        mem_req.wr_addr           = pp;
        mem_req.wr_data.free      = 1'b1;
        mem_req.wr_data.order     = lvl;
        mem_req.wr_data.next_link = head_sel;
        mem_req.wr_data.prev_link = NIL_LINK;
      end
      S_P_H_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = hreg[PAGE_W-1:0];
      end
      S_P_H_WR: begin
        mem_req.wr_en             = 1'b1;
        mem_req.wr_addr           = hreg[PAGE_W-1:0];
        mem_req.wr_data           = mem_q;
        mem_req.wr_data.prev_link = {1'b0, pp};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      for (int k = 0; k <= MAX_ORDER; k++) begin
        head[k] <= NIL_LINK;
      end
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr <= clr + PAGE_W'(1);
          if (&clr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            want  <= req_order;
            p     <= req_page;
            state <= (req_op == OP_FREE) ? S_F_START : S_A_START;
          end
        end
        S_A_START: begin
          res_page <= '0;
          if (want > ORD_MAX) begin
            res_status <= ST_NO_MEM;
            state      <= S_DONE;
          end else begin
            lvl   <= want;
            state <= S_A_SCAN;
          end
        end
        S_A_SCAN: begin
          if (!head_sel[PAGE_W]) begin
            p     <= head_sel[PAGE_W-1:0];
            ul    <= head_sel[PAGE_W-1:0];
            ret   <= S_A_SPLIT;
            state <= S_U_RD;
          end else if (lvl == ORD_MAX) begin
            res_status <= ST_NO_MEM;
            state      <= S_DONE;
          end else begin
            lvl <= lvl + ORD_W'(1);
          end
        end
        S_A_SPLIT: begin
          if (lvl > want) begin
            lvl   <= lvl - ORD_W'(1);
            pp    <= split_c;
            ret   <= S_A_SPLIT;
            state <= S_P_WR;
          end else begin
            res_status <= ST_OK;
            res_page   <= p;
            state      <= S_DONE;
          end
        end
        S_F_START: begin
          res_page <= '0;
          if ({1'b0, p} >= page_limit) begin
            res_status <= ST_BAD_FREE;
            state      <= S_DONE;
          end else begin
            state <= S_F_HEAD;
          end
        end
        S_F_HEAD: begin
          if (mem_q.free || mem_q.nothead) begin
            res_status <= ST_BAD_FREE;
            state      <= S_DONE;
          end else begin
            lvl   <= mem_q.order;
            state <= S_F_LOOP;
          end
        end
        S_F_LOOP: begin
          if (bud_ok) begin
            bud   <= bud_c;
            state <= S_F_BUD;
          end else begin
            pp    <= p;
            ret   <= S_DONE;
            state <= S_P_WR;
          end
        end
        S_F_BUD: begin
          if (!mem_q.free || mem_q.order != lvl) begin
            pp    <= p;
            ret   <= S_DONE;
            state <= S_P_WR;
          end else begin
            // buddy data is already in hand: enter the unlink past its read
            ul    <= bud;
            ret   <= S_F_MERGE;
            state <= S_U_GOT;
          end
        end
        S_F_MERGE: begin
          if (bud < p) begin
            p <= bud;
          end
          lvl   <= lvl + ORD_W'(1);
          state <= S_F_LOOP;
        end
        S_U_RD: begin
          state <= S_U_GOT;
        end
        S_U_GOT: begin
          nx <= mem_q.next_link;
          pv <= mem_q.prev_link;
          if (head_sel == {1'b0, ul}) begin
            head[lvl] <= mem_q.next_link;
          end
          if (!mem_q.prev_link[PAGE_W]) begin
            state <= S_U_PV_RD;
          end else if (!mem_q.next_link[PAGE_W]) begin
            state <= S_U_NX_RD;
          end else begin
            state <= ret;
          end
        end
        S_U_PV_RD: begin
          state <= S_U_PV_WR;
        end
        S_U_PV_WR: begin
          state <= nx[PAGE_W] ? ret : S_U_NX_RD;
        end
        S_U_NX_RD: begin
          state <= S_U_NX_WR;
        end
        S_U_NX_WR: begin
          state <= ret;
        end
        S_P_WR: begin
          hreg      <= head_sel;
          head[lvl] <= {1'b0, pp};
          if (ret == S_DONE) begin
            res_status <= ST_OK;
          end
          state <= head_sel[PAGE_W] ? ret : S_P_H_RD;
        end
        S_P_H_RD: begin
          state <= S_P_H_WR;
        end
        S_P_H_WR: begin
          state <= ret;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/buddy_page_allocator_top.sv
// Binary buddy page allocator over up to 1024 page frames, orders 0 to 10.
// An allocate item (operation 0) takes the head of the lowest non-empty
// free list at or above requested_order and splits it down, pushing each
// upper half onto its list; the result gives the block's first page, or
// out_of_memory. A free item (operation 1) merges the block with free
// buddies of equal order below total_pages and pushes the merged block;
// freeing a page that is not an allocated block head, or lies at or beyond
// total_pages, answers status 2 and changes nothing. All per-page state
// sits in one 1024-entry single-port-read, single-port-write memory with a
// registered read; each neighbour link update is a read followed by a
// write-back, and an item's duration is set by the two memory accesses
// per link update and up to ten split or merge steps. After reset the
// block clears every entry of the page memory before in_ready first
// rises; configuration writes are taken throughout. One item is worked
// on at a time; a finished item waits in an output register while the
// next is taken in.
`default_nettype none
module buddy_page_allocator_top
  import bpa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              total_pages_we,
  input  wire logic [CFG_W-1:0]  total_pages,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              operation,
  input  wire logic [ORD_W-1:0]  requested_order,
  input  wire logic [PAGE_W-1:0] page_number,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             status,
  output logic [PAGE_W-1:0]      block_page
);

  localparam logic [CFG_W-1:0] LIMIT_MAX = CFG_W'(PAGE_NUM);

  logic [CFG_W-1:0]  total_pages_reg;
  logic [CFG_W-1:0]  page_limit;
  logic              res_valid;
  logic              res_ready;
  logic [1:0]        res_status;
  logic [PAGE_W-1:0] res_page;
  mem_req_t          mem_req;
  page_entry_t       mem_q;

  // Hold the page count register; values above the memory size act as it.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_pages_reg <= LIMIT_MAX;
    end else if (total_pages_we) begin
      total_pages_reg <= total_pages;
    end
  end

  assign page_limit = (total_pages_reg > LIMIT_MAX) ? LIMIT_MAX : total_pages_reg;

  bpa_page_ram u_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_q)
  );

  bpa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .page_limit (page_limit),
    .req_valid  (in_valid),
    .req_ready  (in_ready),
    .req_op     (operation),
    .req_order  (requested_order),
    .req_page   (page_number),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_status (res_status),
    .res_page   (res_page),
    .mem_req    (mem_req),
    .mem_q      (mem_q)
  );

  // Output register: load a finished item when empty or being drained.
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      status     <= res_status;
      block_page <= res_page;
    end
  end

  // An accepted item keeps the controller busy, so in_ready drops after acceptance.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item taken in back to back");

  // Only successful allocations carry a page number.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (block_page == '0))
    else $error("page number on a failed result");

  // No status code beyond the three defined ones.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_NO_MEM || status == ST_BAD_FREE))
    else $error("undefined status code");

endmodule
`default_nettype wire
